// ===== sv/rhh_pkg.sv =====
// Shared types and constants of the Robin Hood hash table.
// Used by the register block, controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none
package rhh_pkg;

   localparam int          SLOTS_DEF      = 1024;
   localparam int          KEY_BITS_DEF   = 32;
   localparam int          VALUE_BITS_DEF = 16;
   localparam logic [63:0] HASH_MULT      = 64'h9E3779B97F4A7C15;
   localparam logic [3:0]  LG_RESET       = 4'd10;
   localparam int          LG_W           = 5;
   localparam int          PADDR_W        = 3;
   localparam logic        REG_TABLE_SIZE_LOG2 = 1'b0;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_FIND   = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_MUL0,
      OP_MUL1,
      OP_MUL2,
      OP_HOME,
      OP_READ,
      OP_EVAL,
      OP_SHIFT,
      OP_REM_END,
      OP_RESPOND,
      OP_CLR_INIT,
      OP_CLR_STEP
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       skip;
      logic       eval_done;
      logic       hit;
      logic       shift_stop;
      logic       clr_last;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== sv/robin_hood_hash_table.sv =====
// Top level of the Robin Hood hash table: register block, controller, datapath.
// Depends on rhh_pkg, rhh_csr, rhh_ctrl and rhh_datapath.
//
// One transaction at a time: start is taken while busy is low, and the result
// appears for one cycle on rsp_valid, which the receiver cannot stall. An
// operation first captures the request and runs a three-step 32x32 hash
// multiply, then probes slot by slot, every probe going through the
// registered read port of the single slot memory; a remove that matches
// then examines each slot after the match, the one that stops the shift
// included, and frees the vacated slot, and a finish step ends each transaction.
// Insert into a full table and the unused action skip the hash and the probe.
// After reset and after every write of table_size_log2 a clearing pass
// empties the memory, with busy high.
`timescale 1ns / 1ps
`default_nettype none
module robin_hood_hash_table #(
   parameter int SLOTS      = rhh_pkg::SLOTS_DEF,
   parameter int KEY_BITS   = rhh_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_action,
   input  wire logic [KEY_BITS-1:0]           req_key,
   input  wire logic [VALUE_BITS-1:0]         req_value,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic      [VALUE_BITS-1:0]         rsp_value_out,
   output logic      [1:0]                    rsp_status,
   output logic      [$clog2(SLOTS+1)-1:0]    rsp_occupancy,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [rhh_pkg::PADDR_W-1:0]   paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready
);
   import rhh_pkg::*;

   dp_cmd_type      cmd;
   dp_status_type   status;
   logic [LG_W-1:0] eff_lg;
   logic            clear_req;

   rhh_csr #(.SLOTS(SLOTS)) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .eff_lg   (eff_lg),
      .clear_req(clear_req)
   );

   rhh_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .clear_req(clear_req),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   rhh_datapath #(
      .SLOTS     (SLOTS),
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .eff_lg       (eff_lg),
      .req_action   (req_action),
      .req_key      (req_key),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_value_out(rsp_value_out),
      .rsp_status   (rsp_status),
      .rsp_occupancy(rsp_occupancy)
   );

endmodule
`default_nettype wire

// ===== sv/rhh_csr.sv =====
// APB register block holding table_size_log2.
// Depends on rhh_pkg; raises a clear request on every write to the register.
`timescale 1ns / 1ps
`default_nettype none
module rhh_csr #(
   parameter int SLOTS = rhh_pkg::SLOTS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [rhh_pkg::PADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic      [31:0]                prdata,
   output logic                            pready,
   output logic      [rhh_pkg::LG_W-1:0]   eff_lg,
   output logic                            clear_req
);
   import rhh_pkg::*;

   localparam int MAX_LG = $clog2(SLOTS + 1) - 1;

   logic [3:0] lg_ff, lg_in;
   logic       wr_hit;

   assign pready    = 1'b1;
   assign wr_hit    = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE_LOG2);
   assign clear_req = wr_hit;
   assign lg_in     = wr_hit ? pwdata[3:0] : lg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_ff <= LG_RESET;
      end else begin
         lg_ff <= lg_in;
      end
   end

   always_comb begin
      eff_lg = {1'b0, lg_ff};
      if (eff_lg < LG_W'(1)) begin
         eff_lg = LG_W'(1);
      end
      if (eff_lg > LG_W'(MAX_LG)) begin
         eff_lg = LG_W'(MAX_LG);
      end
      prdata = (paddr[2] == REG_TABLE_SIZE_LOG2) ? {28'd0, lg_ff} : 32'd0;
   end

endmodule
`default_nettype wire

// ===== sv/rhh_datapath.sv =====
// Datapath: slot memory, hash multiplier, probe and shift registers, results.
// Depends on rhh_pkg; driven by rhh_ctrl through dp_cmd_type.
`timescale 1ns / 1ps
`default_nettype none
module rhh_datapath #(
   parameter int SLOTS      = rhh_pkg::SLOTS_DEF,
   parameter int KEY_BITS   = rhh_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rhh_pkg::dp_cmd_type           cmd,
   output rhh_pkg::dp_status_type             status,
   input  wire logic      [rhh_pkg::LG_W-1:0] eff_lg,
   input  wire logic      [1:0]               req_action,
   input  wire logic      [KEY_BITS-1:0]      req_key,
   input  wire logic      [VALUE_BITS-1:0]    req_value,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic           [VALUE_BITS-1:0]    rsp_value_out,
   output logic           [1:0]               rsp_status,
   output logic           [$clog2(SLOTS+1)-1:0] rsp_occupancy
);
   import rhh_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int N_W   = IDX_W + 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef struct packed {
      logic                  valid;
      logic [IDX_W-1:0]      distance;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } slot_type;

   slot_type mem [SLOTS];
   slot_type rd_ff, wdata;
   logic     we, re;

   logic [1:0]            action_ff, action_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] cv_ff, cv_in;
   logic [IDX_W-1:0]      cd_ff, cd_in;
   logic [IDX_W-1:0]      cur_ff, cur_in, prev_ff, prev_in, waddr;
   logic [N_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  skip_ff, skip_in;
   logic [63:0]           prod_ff, prod_in;
   logic [31:0]           cross_ff, cross_in;
   logic                  found_ff, found_in;
   logic [VALUE_BITS-1:0] vout_ff, vout_in;
   logic [1:0]            stat_ff, stat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;

   logic [N_W-1:0]   size;
   logic [IDX_W-1:0] mask, cur_next, home;
   logic [63:0]      kx, hash, hash_sh;
   logic [31:0]      mul_a, mul_b;
   logic [63:0]      mul;
   logic             ins_done, p_miss, p_hit, sh_stop;

   assign size     = N_W'(1) << eff_lg;
   assign mask     = IDX_W'(size - N_W'(1));
   assign cur_next = (cur_ff + IDX_W'(1)) & mask;
   assign kx       = 64'(key_ff);
   assign hash     = prod_ff + {cross_ff, 32'd0};
   assign hash_sh  = hash >> (7'd64 - {2'b00, eff_lg});
   assign home     = IDX_W'(hash_sh) & mask;
   assign mul      = mul_a * mul_b;

   assign ins_done = (n_ff == size) || !rd_ff.valid;
   assign p_miss   = (n_ff == size) || !rd_ff.valid || (n_ff > N_W'(rd_ff.distance));
   assign p_hit    = !p_miss && (rd_ff.key == key_ff);
   assign sh_stop  = (n_ff == size) || !rd_ff.valid || (rd_ff.distance == '0);

   always_comb begin
      status.action     = action_ff;
      status.skip       = skip_ff;
      status.hit        = (action_ff != ACT_INSERT) && p_hit;
      status.eval_done  = (action_ff == ACT_INSERT) ? ins_done : (p_miss || p_hit);
      status.shift_stop = sh_stop;
      status.clr_last   = (cur_ff == IDX_W'(SLOTS - 1));
   end

   always_comb begin
      mul_a = kx[31:0];
      mul_b = HASH_MULT[31:0];
      case (cmd.op)
         OP_MUL1: begin
            mul_b = HASH_MULT[63:32];
         end
         OP_MUL2: begin
            mul_a = kx[63:32];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      action_in    = action_ff;
      key_in       = key_ff;
      cv_in        = cv_ff;
      cd_in        = cd_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      skip_in      = skip_ff;
      prod_in      = prod_ff;
      cross_in     = cross_ff;
      found_in     = found_ff;
      vout_in      = vout_ff;
      stat_in      = stat_ff;
      rsp_valid_in = 1'b0;
      occ_in       = occ_ff;
      we           = 1'b0;
      re           = 1'b0;
      waddr        = cur_ff;
      wdata        = '{valid: 1'b1, distance: cd_ff, key: key_ff, value: cv_ff};
      case (cmd.op)
         OP_LOAD: begin
            action_in = req_action;
            key_in    = req_key;
            cv_in     = req_value;
            found_in  = 1'b0;
            vout_in   = '0;
            stat_in   = ST_OK;
            skip_in   = 1'b0;
            if (req_action == ACT_NONE) begin
               skip_in = 1'b1;
            end else if (req_action == ACT_INSERT && N_W'(count_ff) >= size) begin
               skip_in = 1'b1;
               stat_in = ST_FULL;
            end
         end
         OP_MUL0: begin
            prod_in = mul;
         end
         OP_MUL1: begin
            cross_in = mul[31:0];
         end
         OP_MUL2: begin
            cross_in = cross_ff + mul[31:0];
         end
         OP_HOME: begin
            cur_in = home;
            cd_in  = '0;
            n_in   = '0;
         end
         OP_READ: begin
            re = 1'b1;
         end
         OP_EVAL: begin
            if (action_ff == ACT_INSERT) begin
               if (n_ff == size) begin
               end else if (!rd_ff.valid) begin
                  we       = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  cd_in = cd_ff + IDX_W'(1);
                  if (cd_ff > rd_ff.distance) begin
                     we    = 1'b1;
                     key_in = rd_ff.key;
                     cv_in  = rd_ff.value;
                     cd_in  = rd_ff.distance + IDX_W'(1);
                  end
                  cur_in = cur_next;
                  n_in   = n_ff + N_W'(1);
               end
            end else begin
               if (p_miss) begin
                  stat_in = ST_NOT_FOUND;
               end else if (p_hit) begin
                  found_in = 1'b1;
                  if (action_ff == ACT_FIND) begin
                     vout_in = rd_ff.value;
                  end
                  prev_in = cur_ff;
                  cur_in  = cur_next;
                  n_in    = '0;
               end else begin
                  cur_in = cur_next;
                  n_in   = n_ff + N_W'(1);
               end
            end
         end
         OP_SHIFT: begin
            if (!sh_stop) begin
               we             = 1'b1;
               waddr          = prev_ff;
               wdata          = rd_ff;
               wdata.distance = rd_ff.distance - IDX_W'(1);
               prev_in        = cur_ff;
               cur_in         = cur_next;
               n_in           = n_ff + N_W'(1);
            end
         end
         OP_REM_END: begin
            we          = 1'b1;
            waddr       = prev_ff;
            wdata.valid = 1'b0;
            if (count_ff != '0) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_RESPOND: begin
            rsp_valid_in = 1'b1;
            occ_in       = count_ff;
         end
         OP_CLR_INIT: begin
            cur_in   = '0;
            count_in = '0;
         end
         OP_CLR_STEP: begin
            we          = 1'b1;
            wdata.valid = 1'b0;
            cur_in      = cur_ff + IDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         skip_ff      <= 1'b0;
         action_ff    <= ACT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         skip_ff      <= skip_in;
         action_ff    <= action_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff   <= key_in;
      cv_ff    <= cv_in;
      cd_ff    <= cd_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      n_ff     <= n_in;
      prod_ff  <= prod_in;
      cross_ff <= cross_in;
      found_ff <= found_in;
      vout_ff  <= vout_in;
      stat_ff  <= stat_in;
      occ_ff   <= occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = found_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_status    = stat_ff;
   assign rsp_occupancy = occ_ff;

endmodule
`default_nettype wire

// ===== sv/rhh_ctrl.sv =====
// Controller state machine sequencing hash, probe, insert, shift and clear.
// Depends on rhh_pkg; commands rhh_datapath and reads its status.
`timescale 1ns / 1ps
`default_nettype none
module rhh_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  clear_req,
   input  wire rhh_pkg::dp_status_type status,
   output rhh_pkg::dp_cmd_type        cmd,
   output logic                       busy
);
   import rhh_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CLR_INIT, S_CLR, S_PREP, S_MUL0, S_MUL1, S_MUL2, S_HOME,
      S_READ, S_EVAL, S_SREAD, S_SEVAL, S_REM_END, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_PREP;
            end
         end
         S_CLR_INIT: begin
            cmd.op   = OP_CLR_INIT;
            state_in = S_CLR;
         end
         S_CLR: begin
            cmd.op = OP_CLR_STEP;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_PREP: begin
            state_in = status.skip ? S_FINISH : S_MUL0;
         end
         S_MUL0: begin
            cmd.op   = OP_MUL0;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.op   = OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = OP_MUL2;
            state_in = S_HOME;
         end
         S_HOME: begin
            cmd.op   = OP_HOME;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.op   = OP_READ;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.op = OP_EVAL;
            if (!status.eval_done) begin
               state_in = S_READ;
            end else if (status.hit && status.action == ACT_REMOVE) begin
               state_in = S_SREAD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SREAD: begin
            cmd.op   = OP_READ;
            state_in = S_SEVAL;
         end
         S_SEVAL: begin
            cmd.op   = OP_SHIFT;
            state_in = status.shift_stop ? S_REM_END : S_SREAD;
         end
         S_REM_END: begin
            cmd.op   = OP_REM_END;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.op   = OP_RESPOND;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (clear_req) begin
         cmd.op   = OP_IDLE;
         state_in = S_CLR_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire
